// File: hdl/coordination_restrict_rows_macros.svh
// Assertion macros for the coordination restriction rows block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef COORDINATION_RESTRICT_ROWS_MACROS_SVH
`define COORDINATION_RESTRICT_ROWS_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define CRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CRR_ASSERT_NOW(label, ante, cons, msg)
`define CRR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hdl/crr_pkg.sv
// Package for the coordination restriction rows block: widths, types,
// relation tables and the controller/datapath command structs. No dependencies.
package crr_pkg;

  localparam int IDX_W   = 5;
  localparam int POS_W   = 6;
  localparam int PC_W    = 7;
  localparam int SCORE_W = 16;
  localparam int COL_W   = 64;

  localparam logic [PC_W-1:0] MAX_PHRASES = PC_W'(COL_W);
  localparam logic [PC_W-1:0] PC_RESET    = PC_W'(64);

  typedef enum logic [1:0] {
    TAB_SEL_PLAIN,
    TAB_SEL_POST_STRONG,
    TAB_SEL_PRE_STRONG
  } tab_sel_t;

  typedef enum logic {
    ST_IDLE,
    ST_ROWS
  } state_t;

  // rel_t encodes a row or column relation, 0..3
  typedef logic [1:0] rel_t;
  // table indexed [row relation][column relation]
  typedef logic [3:0][3:0] tab_t;

  localparam tab_t TAB_PLAIN       = {4'b0011, 4'b0011, 4'b1011, 4'b1011};
  localparam tab_t TAB_POST_STRONG = {4'b0011, 4'b0011, 4'b1011, 4'b1000};
  localparam tab_t TAB_PRE_STRONG  = {4'b0011, 4'b0000, 4'b1010, 4'b1010};

  typedef struct packed {
    logic [IDX_W-1:0]          pre_index;
    logic [IDX_W-1:0]          post_index;
    logic [POS_W-1:0]          pre_start;
    logic [POS_W-1:0]          pre_key;
    logic [POS_W-1:0]          pre_end;
    logic [POS_W-1:0]          post_start;
    logic [POS_W-1:0]          post_key;
    logic [POS_W-1:0]          post_end;
    logic                      pre_strong;
    logic                      post_strong;
    logic signed [SCORE_W-1:0] pre_score;
    logic signed [SCORE_W-1:0] post_score;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] row_number;
    logic [COL_W-1:0] column_mask;
    logic [COL_W-1:0] row_bits;
    logic [IDX_W-1:0] revised_index;
    logic             last_row;
  } row_t;

  typedef struct packed {
    logic capture;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

  function automatic logic tab_bit(tab_sel_t sel, rel_t rp, rel_t rq);
    logic b;
    unique case (sel)
      TAB_SEL_PLAIN:       b = TAB_PLAIN[rp][rq];
      TAB_SEL_POST_STRONG: b = TAB_POST_STRONG[rp][rq];
      TAB_SEL_PRE_STRONG:  b = TAB_PRE_STRONG[rp][rq];
      default:             b = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/crr_in_if.sv
// Input channel interface: valid/ready plus the pair of coordinate structures.
// Depends on crr_pkg for field widths.
interface crr_in_if;
  logic                               valid;
  logic                               ready;
  logic [crr_pkg::IDX_W-1:0]          pre_index;
  logic [crr_pkg::IDX_W-1:0]          post_index;
  logic [crr_pkg::POS_W-1:0]          pre_start;
  logic [crr_pkg::POS_W-1:0]          pre_key;
  logic [crr_pkg::POS_W-1:0]          pre_end;
  logic [crr_pkg::POS_W-1:0]          post_start;
  logic [crr_pkg::POS_W-1:0]          post_key;
  logic [crr_pkg::POS_W-1:0]          post_end;
  logic                               pre_strong;
  logic                               post_strong;
  logic signed [crr_pkg::SCORE_W-1:0] pre_score;
  logic signed [crr_pkg::SCORE_W-1:0] post_score;

  modport source (
    output valid, pre_index, post_index, pre_start, pre_key, pre_end,
           post_start, post_key, post_end, pre_strong, post_strong,
           pre_score, post_score,
    input  ready
  );

  modport sink (
    input  valid, pre_index, post_index, pre_start, pre_key, pre_end,
           post_start, post_key, post_end, pre_strong, post_strong,
           pre_score, post_score,
    output ready
  );
endinterface

// File: hdl/crr_out_if.sv
// Result channel interface: valid/ready plus one restriction row.
// Depends on crr_pkg for field widths.
interface crr_out_if;
  logic                      valid;
  logic                      ready;
  logic [crr_pkg::POS_W-1:0] row_number;
  logic [crr_pkg::COL_W-1:0] column_mask;
  logic [crr_pkg::COL_W-1:0] row_bits;
  logic [crr_pkg::IDX_W-1:0] revised_index;
  logic                      last_row;

  modport source (
    output valid, row_number, column_mask, row_bits, revised_index, last_row,
    input  ready
  );

  modport sink (
    input  valid, row_number, column_mask, row_bits, revised_index, last_row,
    output ready
  );
endinterface

// File: hdl/coordination_restrict_rows.sv
// Top level of the coordination restriction rows block: ties the controller
// and datapath to the channel interfaces. Depends on crr_pkg, crr_in_if,
// crr_out_if, crr_ctrl, crr_datapath and the assertion macro header.
//
//   channel | direction | handshake       | transaction
//   --------+-----------+-----------------+---------------------------------
//   in_ch   | in        | valid/ready     | two coordinate structures
//   out_ch  | out       | valid/ready     | one restriction row
//   cfg     | in        | cfg_we          | phrase_count write
//
// One input transaction yields key+1 row transactions (up to 64), one per
// cycle while the sink keeps ready high; the row counter in the datapath
// sets this, once the input has been captured. The next input is taken
// once the last row sits in the output register, even if not yet drained.
// Reset (rst_n low, synchronous) returns to idle, drops out valid and sets
// phrase_count to 64. A stalled sink holds the output register and the row
// counter until ready returns.
`include "coordination_restrict_rows_macros.svh"

module coordination_restrict_rows (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [crr_pkg::PC_W-1:0] cfg_wdata,
  crr_in_if.sink                   in_ch,
  crr_out_if.source                out_ch
);
  import crr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  item_t      item;
  row_t       row;

  // gather the input payload into one struct for the datapath
  assign item = '{pre_index:   in_ch.pre_index,
                  post_index:  in_ch.post_index,
                  pre_start:   in_ch.pre_start,
                  pre_key:     in_ch.pre_key,
                  pre_end:     in_ch.pre_end,
                  post_start:  in_ch.post_start,
                  post_key:    in_ch.post_key,
                  post_end:    in_ch.post_end,
                  pre_strong:  in_ch.pre_strong,
                  post_strong: in_ch.post_strong,
                  pre_score:   in_ch.pre_score,
                  post_score:  in_ch.post_score};

  crr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  crr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .row       (row)
  );

  // drive the result payload straight from the output register
  assign out_ch.row_number    = row.row_number;
  assign out_ch.column_mask   = row.column_mask;
  assign out_ch.row_bits      = row.row_bits;
  assign out_ch.revised_index = row.revised_index;
  assign out_ch.last_row      = row.last_row;

  // after capturing a transaction, hold off the next until rows are out
  `CRR_ASSERT_NEXT(a_busy_after_capture, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken while rows pending")
  // loading the final row frees the input side
  `CRR_ASSERT_NEXT(a_idle_after_last, cmd.emit && sts.last, in_ch.ready, "not idle after final row")
  // never overwrite a row that the sink has not taken
  `CRR_ASSERT_NOW(a_no_overwrite, cmd.emit, !out_ch.valid || out_ch.ready, "pending row overwritten")

endmodule

// File: hdl/crr_ctrl.sv
// Controller for the restriction row block: idle/rows state machine and
// output valid flag. Depends on crr_pkg.
module crr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  crr_pkg::dp_status_t sts,
  output crr_pkg::ctrl_cmd_t  cmd
);
  import crr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register may be loaded when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.emit    = 1'b0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_ROWS;
        end
      end
      ST_ROWS: begin
        if (slot_free) begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/crr_datapath.sv
// Datapath for the restriction row block: phrase count register, captured
// structures, row counter, per-column relation logic and output register.
// Depends on crr_pkg.
module crr_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [crr_pkg::PC_W-1:0]   cfg_wdata,
  input  crr_pkg::item_t             item,
  input  crr_pkg::ctrl_cmd_t         cmd,
  output crr_pkg::dp_status_t        sts,
  output crr_pkg::row_t              row
);
  import crr_pkg::*;

  logic [PC_W-1:0]  pc_r;
  item_t            item_r;
  logic             revise_pre_r, revise_pre_nxt;
  tab_sel_t         tab_sel_r, tab_sel_nxt;
  logic [POS_W-1:0] key_r;
  logic [IDX_W-1:0] idx_r;
  logic [POS_W-1:0] row_cnt_r;
  row_t             row_r;

  logic [PC_W-1:0]  limit;
  logic [PC_W-1:0]  key_p1;
  rel_t             rp;
  logic             row_all_ones;
  logic [COL_W-1:0] mask;
  logic [COL_W-1:0] bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_RESET;
    end else if (cfg_we) begin
      pc_r <= cfg_wdata;
    end
  end

  // pick the structure to revise and its table
  always_comb begin
    if (!item.pre_strong && item.post_strong) begin
      revise_pre_nxt = 1'b1;
      tab_sel_nxt    = TAB_SEL_POST_STRONG;
    end else if (item.pre_strong && !item.post_strong) begin
      revise_pre_nxt = 1'b0;
      tab_sel_nxt    = TAB_SEL_PRE_STRONG;
    end else begin
      revise_pre_nxt = (item.pre_score <= item.post_score);
      tab_sel_nxt    = TAB_SEL_PLAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r       <= item;
      revise_pre_r <= revise_pre_nxt;
      tab_sel_r    <= tab_sel_nxt;
      key_r        <= revise_pre_nxt ? item.pre_key : item.post_key;
      idx_r        <= revise_pre_nxt ? item.pre_index : item.post_index;
      row_cnt_r    <= '0;
    end else if (cmd.emit) begin
      row_cnt_r    <= row_cnt_r + POS_W'(1);
    end
    if (cmd.emit) begin
      row_r <= '{row_number: row_cnt_r, column_mask: mask, row_bits: bits,
                 revised_index: idx_r, last_row: (row_cnt_r == key_r)};
    end
  end

  assign limit  = (pc_r > MAX_PHRASES) ? MAX_PHRASES : pc_r;
  assign key_p1 = {1'b0, item_r.pre_key} + PC_W'(1);

  // row relation, shared by all columns of the current row
  always_comb begin
    row_all_ones = 1'b0;
    if (revise_pre_r) begin
      if (key_p1 < {1'b0, item_r.post_start}) begin
        rp = 2'd0;
      end else if (key_p1 == {1'b0, item_r.post_start}) begin
        rp = 2'd1;
      end else if (row_cnt_r < item_r.post_start) begin
        rp = 2'd2;
      end else begin
        rp = 2'd3;
      end
    end else begin
      row_all_ones = (item_r.pre_end < row_cnt_r);
      if (key_p1 < {1'b0, row_cnt_r}) begin
        rp = 2'd0;
      end else if (key_p1 == {1'b0, row_cnt_r}) begin
        rp = 2'd1;
      end else if (item_r.pre_start < row_cnt_r) begin
        rp = 2'd2;
      end else begin
        rp = 2'd3;
      end
    end
  end

  // column relations and table lookup, one independent slice per column
  always_comb begin
    logic [POS_W-1:0] cc;
    rel_t             rq;
    logic             b;
    for (int c = 0; c < COL_W; c++) begin
      cc      = POS_W'(c);
      mask[c] = (cc > key_r) && (PC_W'(c) < limit);
      if (revise_pre_r) begin
        if (cc < item_r.post_key) begin
          rq = 2'd0;
        end else if (cc == item_r.post_key) begin
          rq = 2'd1;
        end else if (cc < item_r.post_end) begin
          rq = 2'd2;
        end else begin
          rq = 2'd3;
        end
        b = (cc < item_r.post_start) ? 1'b1 : tab_bit(tab_sel_r, rp, rq);
      end else begin
        if (item_r.pre_end < item_r.post_key) begin
          rq = 2'd0;
        end else if (item_r.pre_end == item_r.post_key) begin
          rq = 2'd1;
        end else if (item_r.pre_end < cc) begin
          rq = 2'd2;
        end else begin
          rq = 2'd3;
        end
        b = row_all_ones ? 1'b1 : tab_bit(tab_sel_r, rp, rq);
      end
      bits[c] = mask[c] & b;
    end
  end

  assign sts.last = (row_cnt_r == key_r);
  assign row      = row_r;

endmodule
